// ===== hdl/csm_pkg.sv =====
package csm_pkg;

    // default build sizes
    localparam int MAX_SIZE_LOG2_DEF = 16;
    localparam int SAMPLE_BITS_DEF   = 16;

    // field widths
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_THRESHOLD = 2'd2;

    // register reset values
    localparam logic [4:0]        SIZE_LOG2_RST = 5'd16;
    localparam logic [2:0]        MODE_RST      = 3'd0;
    localparam logic signed [15:0] THRESH_RST   = 16'sd16384;

    // write modes
    typedef enum logic [2:0] {
        MODE_DIRECT    = 3'd0,
        MODE_UP_ONLY   = 3'd1,
        MODE_UP_FILL   = 3'd2,
        MODE_DOWN_ONLY = 3'd3,
        MODE_DOWN_FILL = 3'd4
    } wmode_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic decide;
        logic fill_step;
        logic read_issue;
    } csm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic fill_start;
        logic fill_last;
    } csm_stat_t;

endpackage

// ===== hdl/csm_if.sv =====
interface csm_in_if;
    import csm_pkg::*;
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  write_position;
    logic [POS_W-1:0]  read_position;
    logic [POS_W-1:0]  gate_level;
    logic [15:0]       sample_in;

    modport source (output valid, output write_position, output read_position,
                    output gate_level, output sample_in, input ready);
    modport sink   (input valid, input write_position, input read_position,
                    input gate_level, input sample_in, output ready);
endinterface

interface csm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== hdl/csm_ctrl.sv =====
module csm_ctrl
    import csm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  csm_stat_t stat,
    output csm_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_WRITE = 5'b00100,
        S_FILL  = 5'b01000,
        S_READ  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // sequencing of one word: write phase, optional fill run, then read
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.fill_start ? S_FILL : S_READ;
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (out_free)
                begin
                    cmd.read_issue = 1'b1;
                    in_ready       = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load_item = 1'b1;
                        state_next    = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // output word held until taken
    always_comb
    begin
        if (cmd.read_issue)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/csm_datapath.sv =====
module csm_datapath
    import csm_pkg::*;
#(
    parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [POS_W-1:0]      write_position,
    input  logic [POS_W-1:0]      read_position,
    input  logic [POS_W-1:0]      gate_level,
    input  logic [15:0]           sample_in,
    input  csm_cmd_t              cmd,
    output csm_stat_t             stat,
    output logic [15:0]           sample_out
);

    localparam int DEPTH = 1 << MAX_SIZE_LOG2;
    localparam int AW    = MAX_SIZE_LOG2;
    localparam int LGW   = $clog2(MAX_SIZE_LOG2 + 1);
    localparam int SHW   = $clog2(MAX_SIZE_LOG2 + 17);

    // configuration registers
    logic [4:0]        size_reg;
    logic [2:0]        mode_reg;
    logic signed [15:0] thresh_reg;

    // item registers
    logic [AW-1:0]          wcell_reg;
    logic [AW-1:0]          rcell_reg;
    logic [SAMPLE_BITS-1:0] val_reg;
    logic                   gate_ok_reg;

    // write state
    logic [AW-1:0] last_reg;
    logic [AW-1:0] ptr_reg;
    logic          fill_up_reg;
    logic [AW-1:0] clr_ptr_reg;

    // memory
    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    logic [LGW-1:0]         lg_active;
    logic                   moved_up;
    logic                   moved_down;
    logic                   single_wr;
    logic                   fill_start;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;

    // position to cell: floor(pos_biased * 2^lg / 2^16), never above cells-1
    function automatic logic [AW-1:0] to_cell(input logic [POS_W-1:0] pos,
                                              input logic [LGW-1:0] lg);
        logic [POS_W-1:0]    biased;
        logic [AW+POS_W-1:0] wide;
        biased = pos ^ 16'h8000;
        wide   = {biased, {AW{1'b0}}} >> (SHW'(AW + POS_W) - SHW'(lg));
        return wide[AW-1:0];
    endfunction

    // oversized size saturates
    assign lg_active = (size_reg > 5'(MAX_SIZE_LOG2)) ? LGW'(MAX_SIZE_LOG2)
                                                      : LGW'(size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= SIZE_LOG2_RST;
            mode_reg   <= MODE_RST;
            thresh_reg <= THRESH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIZE_LOG2:      size_reg   <= cfg_data[4:0];
                CFG_WRITE_MODE:     mode_reg   <= cfg_data[2:0];
                CFG_GATE_THRESHOLD: thresh_reg <= $signed(cfg_data);
                default:            ;
            endcase
        end
    end

    // capture the incoming word
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            wcell_reg   <= to_cell(write_position, lg_active);
            rcell_reg   <= to_cell(read_position, lg_active);
            val_reg     <= SAMPLE_BITS'($signed(sample_in));
            gate_ok_reg <= $signed(gate_level) >= thresh_reg;
        end
    end

    // write decision against the last write cell
    assign moved_up   = wcell_reg > last_reg;
    assign moved_down = wcell_reg < last_reg;

    always_comb
    begin
        single_wr  = 1'b0;
        fill_start = 1'b0;
        case (mode_reg)
            MODE_DIRECT:    single_wr  = gate_ok_reg;
            MODE_UP_ONLY:   single_wr  = gate_ok_reg && moved_up;
            MODE_DOWN_ONLY: single_wr  = gate_ok_reg && moved_down;
            MODE_UP_FILL:   fill_start = gate_ok_reg && moved_up;
            MODE_DOWN_FILL: fill_start = gate_ok_reg && moved_down;
            default:        ;
        endcase
    end

    assign stat.fill_start = fill_start;
    assign stat.fill_last  = ptr_reg == wcell_reg;
    assign stat.clear_last = &clr_ptr_reg;

    // last cell, fill pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else if (cmd.decide)
        begin
            last_reg <= wcell_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            ptr_reg     <= moved_up ? last_reg + 1'b1 : last_reg - 1'b1;
            fill_up_reg <= moved_up;
        end
        else if (cmd.fill_step)
        begin
            ptr_reg <= fill_up_reg ? ptr_reg + 1'b1 : ptr_reg - 1'b1;
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_ptr_reg <= '0;
        else if (cmd.clear_step)
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
    end

    // single write port
    always_comb
    begin
        mem_we    = cmd.clear_step || (cmd.decide && single_wr) || cmd.fill_step;
        mem_waddr = ptr_reg;
        mem_wdata = val_reg;
        if (cmd.clear_step)
        begin
            mem_waddr = clr_ptr_reg;
            mem_wdata = '0;
        end
        else if (cmd.decide)
        begin
            mem_waddr = wcell_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    // registered read, held as the output word
    always_ff @(posedge clk)
    begin
        if (cmd.read_issue)
            rdata_reg <= mem[rcell_reg];
    end

    assign sample_out = 16'(rdata_reg);

endmodule

// ===== hdl/cv_sample_memory_with_fill.sv =====
// Sample memory addressed by two Q1.15 positions. After reset the block runs a clearing pass over
// all 2^MAX_SIZE_LOG2 cells (one cell a cycle through the single write port) and takes no word
// until it ends; configuration writes are taken throughout. A word then runs a write phase, an
// optional fill run that writes one cell a cycle, and the read, one after another; memory
// writes go through the single write port and never overlap the read. The result sits in the
// registered read data until taken, and the next word is accepted in the read cycle.
module cv_sample_memory_with_fill
    import csm_pkg::*;
#(
    parameter int MAX_SIZE_LOG2 = MAX_SIZE_LOG2_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    csm_in_if.sink                item,
    csm_out_if.source             result
);

    csm_cmd_t  cmd;
    csm_stat_t stat;

    // sequencer
    csm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // store and arithmetic
    csm_datapath #(
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .write_position (item.write_position),
        .read_position  (item.read_position),
        .gate_level     (item.gate_level),
        .sample_in      (item.sample_in),
        .cmd            (cmd),
        .stat           (stat),
        .sample_out     (result.sample_out)
    );

    // no word taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear_step && item.ready))
        else $error("word accepted during clearing pass");

    // an accepted word is decided in the next cycle
    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> cmd.decide)
        else $error("accepted word not decided");

    // a read always produces a result word
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_issue |=> result.valid)
        else $error("read issued without result");

    // write phases never overlap the read
    a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_issue |-> !(cmd.fill_step || cmd.decide || cmd.clear_step))
        else $error("read overlaps a write phase");

endmodule

// ===== test/cv_sample_memory_with_fill_checker.sv =====
module cv_sample_memory_with_fill_checker
    import csm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    csm_in_if                     item,
    csm_out_if                    result,
    output int                    mismatches,
    output int                    pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 1 << MAX_SIZE_LOG2_DEF;

    // shadow copy of the sample store and of the last write cell
    logic [15:0]        shadow_mem [STORE_DEPTH];
    logic [15:0]        prev_cell;

    // shadow registers
    logic [4:0]         size_reg;
    logic [2:0]         mode_reg;
    logic signed [15:0] thresh_reg;

    // read-back words still owed by the block, oldest first
    logic [15:0]        read_back_q [$];
    logic [15:0]        owed_word;
    int                 fail_count;

    assign mismatches = fail_count;

    // position to cell: the top size bits of the position offset by half scale
    function automatic logic [15:0] cell_of(input logic [15:0] pos);
        logic [4:0]  lg;
        logic [31:0] wide;
        lg   = (size_reg > 5'(MAX_SIZE_LOG2_DEF)) ? 5'(MAX_SIZE_LOG2_DEF) : size_reg;
        wide = {16'h0000, pos ^ 16'h8000} << lg;
        return wide[31:16];
    endfunction

    // one word: gated write by mode, move the write cell, then read back
    function automatic logic [15:0] store_and_read(input logic [15:0] wpos, input logic [15:0] rpos,
                                                   input logic [15:0] gate,
                                                   input logic [15:0] value);
        logic [15:0] wcell;
        logic [15:0] rcell;
        int          i;
        wcell = cell_of(wpos);
        rcell = cell_of(rpos);
        if ($signed(gate) >= thresh_reg)
        begin
            case (mode_reg)
                MODE_DIRECT:
                    shadow_mem[wcell] = value;
                MODE_UP_ONLY:
                    if (wcell > prev_cell)
                        shadow_mem[wcell] = value;
                MODE_UP_FILL:
                    if (wcell > prev_cell)
                        for (i = int'(prev_cell) + 1; i <= int'(wcell); i++)
                            shadow_mem[i] = value;
                MODE_DOWN_ONLY:
                    if (wcell < prev_cell)
                        shadow_mem[wcell] = value;
                MODE_DOWN_FILL:
                    if (wcell < prev_cell)
                        for (i = int'(prev_cell) - 1; i >= int'(wcell); i--)
                            shadow_mem[i] = value;
                default:
                    ;
            endcase
        end
        prev_cell = wcell;
        return shadow_mem[rcell];
    endfunction

    // watch config writes and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (shadow_mem[i])
                shadow_mem[i] = '0;
            prev_cell  = '0;
            size_reg   = SIZE_LOG2_RST;
            mode_reg   = MODE_RST;
            thresh_reg = THRESH_RST;
            read_back_q.delete();
            fail_count = 0;
            pending_words <= 0;
        end
        else
        begin
            // compare a word leaving the block with the oldest prediction
            if (result.valid && result.ready)
            begin
                if (read_back_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("sample_out %h arrived with no word outstanding",
                                 result.sample_out);
                    fail_count++;
                end
                else
                begin
                    owed_word = read_back_q.pop_front();
                    if (owed_word !== result.sample_out)
                    begin
                        if (fail_count < 10)
                            $display("sample_out mismatch: expected %h, got %h",
                                     owed_word, result.sample_out);
                        fail_count++;
                    end
                end
            end

            // register writes, unused index ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SIZE_LOG2:      size_reg   = cfg_data[4:0];
                    CFG_WRITE_MODE:     mode_reg   = cfg_data[2:0];
                    CFG_GATE_THRESHOLD: thresh_reg = cfg_data;
                    default:            ;
                endcase
            end

            // predict the word for each accepted sample
            if (item.valid && item.ready)
                read_back_q.push_back(store_and_read(item.write_position, item.read_position,
                                                     item.gate_level, item.sample_in));

            pending_words <= read_back_q.size();
        end
    end

endmodule

// ===== test/cv_sample_memory_with_fill_tb.sv =====
module cv_sample_memory_with_fill_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csm_pkg::*;

    localparam int RANDOM_WORDS = 1350;
    // clearing pass, two full-store fills, then per word up to a 4096-cell fill plus both
    // gaps and a long stall, with a fourfold margin on the worst case
    localparam int RUN_LIMIT = 25_000_000;

    localparam logic [15:0]          POS_MIN        = 16'h8000;
    localparam logic [15:0]          POS_MAX        = 16'h7FFF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;
    localparam logic [2:0]           MODE_UNDEFINED = 3'd7;
    localparam int                   SENDER         = 0;
    localparam int                   RECEIVER       = 1;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    pending_words;
    int                    cycle_count;
    int                    calm_left [2];

    csm_in_if  item_ch ();
    csm_out_if result_ch ();

    cv_sample_memory_with_fill u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    cv_sample_memory_with_fill_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item          (item_ch),
        .result        (result_ch),
        .mismatches    (mismatches),
        .pending_words (pending_words)
    );

    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // idle cycles before a word, with stretches of none
    function automatic int draw_gap(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left[side] = $urandom_range(10, 40);
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // unused upper bits of the narrow registers carry noise
    task automatic load_settings(input logic [4:0] size, input logic [2:0] mode,
                                 input logic [15:0] thresh);
        write_reg(CFG_SIZE_LOG2, {11'($urandom), size});
        write_reg(CFG_WRITE_MODE, {13'($urandom), mode});
        write_reg(CFG_GATE_THRESHOLD, thresh);
    endtask

    // stop offering and wait until every word has come back
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_word(input logic [15:0] wpos, input logic [15:0] rpos,
                             input logic [15:0] gate, input logic [15:0] value);
        int gap;
        gap = draw_gap(SENDER);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.write_position <= wpos;
        item_ch.read_position  <= rpos;
        item_ch.gate_level     <= gate;
        item_ch.sample_in      <= value;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic run_directed();
        // reset settings: full store, direct writes, threshold one half
        send_word(POS_MIN, POS_MIN, POS_MAX, POS_MAX);
        send_word(POS_MAX, POS_MAX, 16'h4000, POS_MIN);
        send_word(16'h0000, 16'h0000, 16'h3FFF, 16'h5555);
        send_word(16'h0000, POS_MAX, POS_MIN, 16'hAAAA);
        wait_drained();
        write_reg(CFG_UNUSED, 16'hFFFF);

        // up only: a rise writes, a fall does not
        load_settings(5'd16, MODE_UP_ONLY, POS_MIN);
        send_word(16'h0100, 16'h0100, 16'h0000, 16'h1357);
        send_word(POS_MIN, POS_MIN, 16'h0000, 16'h2468);
        wait_drained();

        // down only: the mirror case
        load_settings(5'd16, MODE_DOWN_ONLY, POS_MIN);
        send_word(16'hC000, 16'hC000, 16'h0000, 16'h0F0F);
        send_word(16'h8001, 16'h8001, 16'h0000, 16'hF0F0);
        wait_drained();

        // full-range fills, the longest words the block can take
        load_settings(5'd16, MODE_UP_FILL, POS_MIN);
        send_word(POS_MAX, 16'h0000, 16'h0000, 16'h6666);
        wait_drained();
        load_settings(5'd16, MODE_DOWN_FILL, POS_MIN);
        send_word(POS_MIN, POS_MAX, 16'h0000, 16'h9999);
        wait_drained();

        // undefined mode writes nothing but moves the write cell, here to cell 600
        load_settings(5'd16, MODE_UNDEFINED, POS_MAX);
        send_word(16'h8258, 16'h8258, POS_MAX, 16'h7777);
        wait_drained();

        // shrink with the write cell left far above the new range
        load_settings(5'd3, MODE_DOWN_FILL, 16'h0000);
        send_word(POS_MIN, 16'h0000, 16'h0000, 16'h4321);
        send_word(POS_MAX, 16'h0000, 16'h0000, 16'h8765);
        wait_drained();

        // size beyond the store saturates
        load_settings(5'd31, MODE_DIRECT, 16'h0000);
        send_word(POS_MAX, POS_MAX, 16'h0000, 16'h0001);
        send_word(16'h8001, 16'h8001, 16'h0000, 16'hFFFE);
        wait_drained();

        // one cell, then two
        load_settings(5'd0, MODE_DIRECT, POS_MIN);
        send_word(POS_MAX, POS_MAX, POS_MIN, 16'hFFFF);
        send_word(POS_MIN, POS_MAX, 16'h1111, 16'h8000);
        wait_drained();
        load_settings(5'd1, MODE_UP_FILL, POS_MIN);
        send_word(16'h0000, 16'h0000, 16'h0000, 16'h2222);
        send_word(16'hFFFF, 16'h0000, 16'h0000, 16'h3333);
        send_word(POS_MAX, POS_MIN, 16'h0000, 16'h4444);
    endtask

    task automatic run_random();
        int          sent;
        int          count;
        int          pick;
        int          lg;
        int          step;
        logic [4:0]  size;
        logic [2:0]  mode;
        logic [15:0] thresh;
        logic [15:0] ramp;
        logic [15:0] wpos;
        logic [15:0] rpos;
        logic [15:0] gate;
        logic [15:0] value;
        bit          falling;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            // settings for this phase, small stores most of the time
            pick = $urandom_range(0, 99);
            if (pick < 55)
                size = 5'($urandom_range(0, 6));
            else if (pick < 85)
                size = 5'($urandom_range(7, 10));
            else if (pick < 95)
                size = 5'($urandom_range(11, 16));
            else
                size = 5'($urandom_range(17, 31));
            mode  = 3'($urandom_range(0, 7));
            lg    = (size > 5'd16) ? 16 : int'(size);
            count = $urandom_range(10, 50);

            // a fill writes one cell per cycle, so filled stores stay modest
            if (mode == MODE_UP_FILL || mode == MODE_DOWN_FILL)
            begin
                if (lg > 12)
                begin
                    size = 5'($urandom_range(9, 12));
                    lg   = int'(size);
                end
                if (lg > 10)
                    count = 8;
            end

            pick = $urandom_range(0, 9);
            if (pick < 2)
                thresh = POS_MIN;
            else if (pick < 3)
                thresh = POS_MAX;
            else if (pick < 5)
                thresh = 16'h0000;
            else
                thresh = 16'($urandom);

            falling = (mode == MODE_DOWN_ONLY || mode == MODE_DOWN_FILL) ||
                      (mode != MODE_UP_ONLY && mode != MODE_UP_FILL && $urandom_range(0, 1) == 1);
            ramp    = 16'($urandom);

            wait_drained();
            load_settings(size, mode, thresh);

            repeat (count)
            begin
                // mostly a slow ramp the way the mode writes, with jumps and extremes
                pick = $urandom_range(0, 99);
                step = $urandom_range(0, 3 << (16 - lg));
                ramp = falling ? ramp - 16'(step) : ramp + 16'(step);
                if (pick < 60)
                    wpos = ramp;
                else if (pick < 85)
                    wpos = 16'($urandom);
                else
                    wpos = corner_value();
                rpos = ($urandom_range(0, 1) == 1) ? wpos : 16'($urandom);
                if ($urandom_range(0, 9) < 7)
                    gate = 16'($urandom_range(int'($signed(thresh)) + 32768, 65535) - 32768);
                else
                    gate = 16'($urandom);
                value = ($urandom_range(0, 9) == 0) ? corner_value() : 16'($urandom);
                send_word(wpos, rpos, gate, value);
            end
            sent += count;

            // park the write cell at the bottom so a later shrink cannot start a huge fill
            if (lg > 8)
            begin
                send_word(POS_MIN, 16'($urandom), 16'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    // receiver: random stalls, and now and then a long hold so the block backs up
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap(RECEIVER);
            if (taken == 150 || taken == 900 || $urandom_range(0, 399) == 0)
                gap = $urandom_range(200, 400);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            taken++;
        end
    end

    // stimulus and verdict
    initial
    begin
        cycle_count              = 0;
        calm_left[SENDER]        = 0;
        calm_left[RECEIVER]      = 0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        item_ch.valid            = 1'b0;
        item_ch.write_position   = '0;
        item_ch.read_position    = '0;
        item_ch.gate_level       = '0;
        item_ch.sample_in        = '0;
        result_ch.ready          = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();
        wait_drained();
        repeat (16) @(posedge clk);

        if (mismatches == 0 && pending_words == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
